// ===== design/qf_pkg.sv =====
// Shared constants and types for the quotient filter insert and lookup unit.
package qf_pkg;
    localparam int QF_QUOTIENT_BITS  = 10;
    localparam int QF_REMAINDER_BITS = 8;
    localparam int QF_QUOTIENT_W     = 10;
    localparam int QF_REMAINDER_W    = 8;
    localparam int QF_FLAG_BITS      = 3;

    localparam logic [2:0] FLAG_SHIFTED = 3'd4;
    localparam logic [2:0] FLAG_CONT    = 3'd2;
    localparam logic [2:0] FLAG_OCC     = 3'd1;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    typedef struct packed {
        logic present;
        logic full_res;
    } t_qf_res;
endpackage

// ===== design/qf_mem.sv =====
// Slot store with one write port and one registered read port with write bypass.
module qf_mem #(
    parameter int QB = qf_pkg::QF_QUOTIENT_BITS,
    parameter int W  = qf_pkg::QF_REMAINDER_BITS + qf_pkg::QF_FLAG_BITS
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [QB-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [QB-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [(1 << QB)];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/qf_ctrl.sv =====
// Sequencer that walks the slot store one slot per cycle for lookups and inserts.
module qf_ctrl #(
    parameter int QB = qf_pkg::QF_QUOTIENT_BITS,
    parameter int RB = qf_pkg::QF_REMAINDER_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_req_type,
    input  logic [QB-1:0]     i_fq,
    input  logic [RB-1:0]     i_fr,
    output logic              o_idle,
    input  logic              i_res_free,
    output logic              o_done,
    output qf_pkg::t_qf_res   o_res,
    output logic              o_we,
    output logic [QB-1:0]     o_waddr,
    output logic [RB+2:0]     o_wdata,
    output logic [QB-1:0]     o_raddr,
    input  logic [RB+2:0]     i_rdata
);
    import qf_pkg::*;

    localparam int W = RB + 3;
    localparam logic [QB:0] SLOTS = {1'b1, {QB{1'b0}}};
    localparam logic [QB:0] ONE   = {{QB{1'b0}}, 1'b1};

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_HEAD, S_BACK, S_RUNS, S_RUNB, S_SCAN, S_CHK, S_SHIFT, S_RESP
    } t_state;

    t_state        r_state, n_state;
    logic [QB-1:0] r_addr, n_addr, r_fq, n_fq, r_b, n_b, r_s, n_s, r_pos, n_pos;
    logic [RB-1:0] r_fr, n_fr;
    logic [QB:0]   r_k, n_k, r_g, n_g, r_used, n_used;
    logic [W-1:0]  r_entry, n_entry;
    logic          r_ins, n_ins, r_was, n_was, r_phase, n_phase, r_first, n_first;
    logic          r_present, n_present, r_full, n_full, r_head, n_head, r_cont, n_cont;

    logic          rd_occ, rd_cont, rd_shf;
    logic [RB-1:0] rd_rem;
    logic [W-1:0]  old;
    logic [QB:0]   g_inc;
    logic          fin_rs, decide;
    logic [QB-1:0] fin_s;

    assign rd_occ  = i_rdata[0];
    assign rd_cont = i_rdata[1];
    assign rd_shf  = i_rdata[2];
    assign rd_rem  = i_rdata[W-1:3];
    assign g_inc   = r_g + ONE;
    assign old     = i_rdata | ((r_first && r_head) ? W'(FLAG_CONT) : W'(0));

    always_comb begin
        n_state = r_state; n_addr = r_addr; n_fq = r_fq; n_fr = r_fr; n_b = r_b;
        n_s = r_s; n_pos = r_pos; n_k = r_k; n_g = r_g; n_used = r_used;
        n_entry = r_entry; n_ins = r_ins; n_was = r_was; n_phase = r_phase;
        n_first = r_first; n_present = r_present; n_full = r_full;
        n_head = r_head; n_cont = r_cont;
        o_we = 1'b0; o_waddr = r_addr; o_wdata = '0; o_done = 1'b0;
        fin_rs = 1'b0; fin_s = r_s; decide = 1'b0;
        case (r_state)
            S_CLR: begin
                o_we = 1'b1;
                n_addr = r_addr + 1'b1;
                if (&r_addr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_fq = i_fq; n_fr = i_fr; n_ins = (i_req_type == REQ_INSERT);
                    n_addr = i_fq; n_present = 1'b0; n_full = 1'b0;
                    n_head = 1'b0; n_cont = 1'b0; n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                n_was = rd_occ;
                if (rd_occ) begin
                    n_b = r_fq; n_k = '0; n_phase = 1'b0; n_state = S_BACK;
                end else begin
                    decide = 1'b1;
                end
            end
            S_BACK: begin
                if (rd_shf && (r_k < SLOTS)) begin
                    n_b = r_b - 1'b1; n_addr = r_b - 1'b1; n_k = r_k + ONE;
                end else if (r_b == r_fq) begin
                    fin_rs = 1'b1; fin_s = r_b;
                end else begin
                    n_s = r_b + 1'b1; n_addr = r_b + 1'b1;
                    n_k = '0; n_g = '0; n_state = S_RUNS;
                end
            end
            S_RUNS: begin
                if (rd_cont && (r_k < SLOTS)) begin
                    n_s = r_s + 1'b1; n_addr = r_s + 1'b1; n_k = r_k + ONE;
                end else begin
                    n_b = r_b + 1'b1; n_addr = r_b + 1'b1; n_k = '0; n_state = S_RUNB;
                end
            end
            S_RUNB: begin
                if (!rd_occ && (r_k < SLOTS)) begin
                    n_b = r_b + 1'b1; n_addr = r_b + 1'b1; n_k = r_k + ONE;
                end else begin
                    n_g = g_inc;
                    if ((r_b != r_fq) && (g_inc < SLOTS)) begin
                        n_s = r_s + 1'b1; n_addr = r_s + 1'b1; n_k = '0; n_state = S_RUNS;
                    end else begin
                        fin_rs = 1'b1; fin_s = r_s;
                    end
                end
            end
            S_SCAN: begin
                if (!r_first && (!rd_cont || (r_k >= SLOTS))) begin
                    decide = 1'b1;
                end else if (rd_rem == r_fr) begin
                    n_present = 1'b1; decide = 1'b1;
                end else if (rd_rem > r_fr) begin
                    decide = 1'b1;
                end else begin
                    n_pos = r_pos + 1'b1; n_addr = r_pos + 1'b1;
                    n_k = r_k + ONE; n_first = 1'b0;
                end
                if (decide) begin
                    n_head = (r_pos == r_s); n_cont = (r_pos != r_s);
                end
            end
            S_CHK: begin
                if (i_rdata[2:0] == 3'd0) begin
                    o_we = 1'b1; o_wdata = {r_fr, FLAG_OCC};
                    n_used = r_used + ONE; n_state = S_RESP;
                end else if (!r_was) begin
                    o_we = 1'b1; o_wdata = i_rdata | W'(FLAG_OCC);
                    n_b = r_fq; n_k = '0; n_phase = 1'b1; n_state = S_BACK;
                end else begin
                    n_entry = {r_fr, (r_pos != r_fq), r_cont, 1'b0};
                    n_addr = r_pos; n_k = '0; n_first = 1'b1; n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_we = 1'b1; o_wdata = {r_entry[W-1:1], old[0]};
                if ((old[2:0] == 3'd0) || ((r_k + ONE) >= SLOTS)) begin
                    n_used = r_used + ONE; n_state = S_RESP;
                end else begin
                    n_entry = {old[W-1:3], 1'b1, old[1], 1'b0};
                    n_addr = r_addr + 1'b1; n_k = r_k + ONE; n_first = 1'b0;
                end
            end
            S_RESP: begin
                if (i_res_free) begin
                    o_done = 1'b1; n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin_rs) begin
            n_s = fin_s; n_pos = fin_s; n_addr = fin_s; n_k = '0; n_first = 1'b1;
            if (!r_phase) begin
                n_state = S_SCAN;
            end else begin
                n_head = 1'b0; n_cont = 1'b0;
                n_entry = {r_fr, (fin_s != r_fq), 2'b00};
                n_state = S_SHIFT;
            end
        end

        if (decide) begin
            if (!r_ins || n_present) begin
                n_state = S_RESP;
            end else if (r_used >= SLOTS) begin
                n_full = 1'b1; n_state = S_RESP;
            end else begin
                n_addr = r_fq; n_state = S_CHK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_addr  <= '0;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_used  <= n_used;
        end
        r_fq <= n_fq; r_fr <= n_fr; r_b <= n_b; r_s <= n_s; r_pos <= n_pos;
        r_k <= n_k; r_g <= n_g; r_entry <= n_entry; r_ins <= n_ins; r_was <= n_was;
        r_phase <= n_phase; r_first <= n_first; r_present <= n_present;
        r_full <= n_full; r_head <= n_head; r_cont <= n_cont;
    end

    assign o_idle         = (r_state == S_IDLE);
    assign o_res.present  = r_present;
    assign o_res.full_res = r_full;
    assign o_raddr        = n_addr;
endmodule

// ===== design/quotient_filter_insert_lookup_unit.sv =====
// Top level of the quotient filter insert and lookup unit.
// The input channel (i_in_valid, o_in_ready) carries a request type, a quotient
// and a remainder; only the low QB quotient bits and RB remainder bits are used.
// A lookup reports whether the remainder is stored in the run of the quotient.
// An insert adds it in sorted order and shifts later slots of the cluster right.
// The output channel (o_out_valid, i_out_ready) carries present and full_res.
// After the first read of the canonical slot the sequencer walks back to the
// cluster start, over runs, along the run and across the shift, one slot per
// cycle; a lookup of an unoccupied quotient needs no walk, and an insert into
// an empty slot only writes that slot. A single slot memory is read or written
// once per cycle. o_in_ready rises in the same cycle as o_out_valid, so an item
// is taken only after the result of the previous item has reached the output
// register.
// The result sits in an output register, so a new item is taken while the
// result waits; a second result waits in the sequencer until that one is taken.
// After reset the store is cleared one slot a cycle, over every slot, with
// o_in_ready low; the used-slot count is reset to zero.
module quotient_filter_insert_lookup_unit #(
    parameter int QB = qf_pkg::QF_QUOTIENT_BITS,
    parameter int RB = qf_pkg::QF_REMAINDER_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_req_type,
    input  logic [qf_pkg::QF_QUOTIENT_W-1:0]  i_quotient,
    input  logic [qf_pkg::QF_REMAINDER_W-1:0] i_remainder,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_present,
    output logic                              o_full_res
);
    import qf_pkg::*;

    localparam int W = RB + 3;

    logic          idle, done, we, res_free;
    logic [QB-1:0] waddr, raddr;
    logic [W-1:0]  wdata, rdata;
    t_qf_res       res;
    logic          r_out_valid;
    t_qf_res       r_res;

    assign res_free = !r_out_valid || i_out_ready;

    qf_ctrl #(.QB(QB), .RB(RB)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_in_valid && idle),
        .i_req_type (i_req_type),
        .i_fq       (QB'(i_quotient)),
        .i_fr       (RB'(i_remainder)),
        .o_idle     (idle),
        .i_res_free (res_free),
        .o_done     (done),
        .o_res      (res),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_raddr    (raddr),
        .i_rdata    (rdata)
    );

    qf_mem #(.QB(QB), .W(W)) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (done) begin
            r_res <= res;
        end
    end

    assign o_in_ready  = idle;
    assign o_out_valid = r_out_valid;
    assign o_present   = r_res.present;
    assign o_full_res  = r_res.full_res;
endmodule

// ===== design/qf_checker.sv =====
// Port-level assertions for the quotient filter unit and their bind.
module qf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_present,
    input logic o_full_res
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_present)
            && $stable(o_full_res))
        else $error("Result changed while stalled.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("Ready stayed high after an item was accepted.");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_present && o_full_res))
        else $error("Present and full flagged together.");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("Ports active right after reset.");
endmodule

bind quotient_filter_insert_lookup_unit qf_checker u_qf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_present   (o_present),
    .o_full_res  (o_full_res)
);

// ===== verif/quotient_filter_insert_lookup_unit_tb.sv =====
// Testbench for the quotient filter insert and lookup unit with a slot-level predictor.
`timescale 1ns / 100ps

module quotient_filter_insert_lookup_unit_tb;
    import qf_pkg::*;

    class qf_scoreboard;
        localparam int SLOTS = 1 << QF_QUOTIENT_BITS;

        logic [QF_REMAINDER_BITS+2:0] slots[SLOTS];
        int unsigned used;
        bit present_q[$];
        bit full_q[$];
        int errors;
        int n_lookups, n_inserts, n_hits, n_refused, n_results;

        function new();
            foreach (slots[i]) slots[i] = '0;
            used = 0;
            errors = 0;
            n_lookups = 0;
            n_inserts = 0;
            n_hits = 0;
            n_refused = 0;
            n_results = 0;
        endfunction

        function int unsigned nxt(int unsigned i);
            return (i + 1) % SLOTS;
        endfunction

        function int unsigned prv(int unsigned i);
            return (i + SLOTS - 1) % SLOTS;
        endfunction

        function bit occ(int unsigned i);
            return (slots[i] & FLAG_OCC) != 0;
        endfunction

        function bit cont(int unsigned i);
            return (slots[i] & FLAG_CONT) != 0;
        endfunction

        function bit shf(int unsigned i);
            return (slots[i] & FLAG_SHIFTED) != 0;
        endfunction

        function int unsigned run_begin(int unsigned fq);
            int unsigned b, s, n, g, k;
            b = fq;
            n = 0;
            while (shf(b) && n < SLOTS) begin
                b = prv(b);
                n++;
            end
            s = b;
            g = 0;
            while (b != fq && g < SLOTS) begin
                s = nxt(s);
                k = 0;
                while (cont(s) && k < SLOTS) begin
                    s = nxt(s);
                    k++;
                end
                b = nxt(b);
                k = 0;
                while (!occ(b) && k < SLOTS) begin
                    b = nxt(b);
                    k++;
                end
                g++;
            end
            return s;
        endfunction

        function void note_input(logic req, logic [QF_QUOTIENT_W-1:0] q,
                                 logic [QF_REMAINDER_W-1:0] r);
            int unsigned fq, pos, s, i, k;
            logic [QF_REMAINDER_BITS-1:0] fr;
            logic [QF_REMAINDER_BITS+2:0] entry, old;
            bit was, hit, head, is_cont;
            fq = 32'(q[QF_QUOTIENT_BITS-1:0]);
            fr = r[QF_REMAINDER_BITS-1:0];
            was = occ(fq);
            hit = 0;
            head = 0;
            is_cont = 0;
            pos = fq;
            if (was) begin
                s = run_begin(fq);
                pos = s;
                k = 0;
                forever begin
                    if (slots[pos][QF_REMAINDER_BITS+2:3] == fr) begin
                        hit = 1;
                        break;
                    end
                    if (slots[pos][QF_REMAINDER_BITS+2:3] > fr) break;
                    pos = nxt(pos);
                    k++;
                    if (!cont(pos) || k >= SLOTS) break;
                end
                head = (pos == s);
                is_cont = !head;
            end
            if (req == REQ_INSERT) n_inserts++;
            else n_lookups++;
            if (hit) n_hits++;
            present_q = {present_q, hit};
            if (req != REQ_INSERT || hit) begin
                full_q = {full_q, 1'b0};
                return;
            end
            if (used >= SLOTS) begin
                full_q = {full_q, 1'b1};
                n_refused++;
                return;
            end
            full_q = {full_q, 1'b0};
            used++;
            if (slots[fq][2:0] == 3'b000) begin
                slots[fq] = {fr, FLAG_OCC};
                return;
            end
            if (!was) begin
                slots[fq] = slots[fq] | FLAG_OCC;
                pos = run_begin(fq);
                is_cont = 0;
                head = 0;
            end
            if (head) slots[pos] = slots[pos] | FLAG_CONT;
            entry = {fr, 3'b000};
            if (is_cont) entry = entry | FLAG_CONT;
            if (pos != fq) entry = entry | FLAG_SHIFTED;
            i = pos;
            for (k = 0; k < SLOTS; k++) begin
                old = slots[i];
                slots[i] = (old & FLAG_OCC) | entry;
                if (old[2:0] == 3'b000) break;
                entry = (old & ~{{QF_REMAINDER_BITS{1'b0}}, FLAG_OCC}) | FLAG_SHIFTED;
                i = nxt(i);
            end
        endfunction

        task report(string what);
            $display("ERROR at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(logic p, logic f);
            bit ep, ef;
            if (present_q.size() == 0) begin
                report($sformatf("result with no item pending (present=%b full_res=%b)", p, f));
                return;
            end
            ep = present_q.pop_front();
            ef = full_q.pop_front();
            n_results++;
            if (p !== ep) report($sformatf("result %0d: present %b, want %b", n_results, p, ep));
            if (f !== ef) report($sformatf("result %0d: full_res %b, want %b", n_results, f, ef));
        endtask

        function int pending();
            return present_q.size();
        endfunction
    endclass

    localparam int HALF_PERIOD = 6;
    localparam int STALL_LIMIT = 40000;
    localparam int SLOTS = 1 << QF_QUOTIENT_BITS;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic                      i_req_type;
    logic [QF_QUOTIENT_W-1:0]  i_quotient;
    logic [QF_REMAINDER_W-1:0] i_remainder;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic                      o_present;
    logic                      o_full_res;

    qf_scoreboard sb = new();
    bit calm = 0;
    int stall_cycles = 0;
    logic [QF_QUOTIENT_W+QF_REMAINDER_W-1:0] stored[$];

    quotient_filter_insert_lookup_unit dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_req_type(i_req_type),
        .i_quotient(i_quotient),
        .i_remainder(i_remainder),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_present(o_present),
        .o_full_res(o_full_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #(HALF_PERIOD) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(0, 99) >= 21);
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_present, o_full_res);
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d cycles with no item moving.", stall_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send(logic req, logic [QF_QUOTIENT_W-1:0] q, logic [QF_REMAINDER_W-1:0] r);
        if (!calm && $urandom_range(0, 99) < 21) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= req;
        i_quotient  <= q;
        i_remainder <= r;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(req, q, r);
        if (req == REQ_INSERT) stored = {stored, {q, r}};
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic send_random(int unsigned base);
        logic req;
        logic [QF_QUOTIENT_W-1:0] q;
        logic [QF_REMAINDER_W-1:0] r;
        logic [QF_QUOTIENT_W+QF_REMAINDER_W-1:0] pick;
        req = ($urandom_range(0, 99) < 55) ? REQ_INSERT : REQ_LOOKUP;
        if (stored.size() != 0 && $urandom_range(0, 99) < 30) begin
            pick = stored[$urandom_range(0, stored.size() - 1)];
            {q, r} = pick;
        end else begin
            if ($urandom_range(0, 99) < 60) q = QF_QUOTIENT_W'(base + $urandom_range(0, 7));
            else q = QF_QUOTIENT_W'($urandom);
            r = ($urandom_range(0, 1) != 0) ? QF_REMAINDER_W'($urandom_range(0, 15))
                                             : QF_REMAINDER_W'($urandom);
        end
        send(req, q, r);
    endtask

    initial begin
        int unsigned base;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_req_type  <= REQ_LOOKUP;
        i_quotient  <= '0;
        i_remainder <= '0;
        i_out_ready <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send(REQ_LOOKUP, 10'd0, 8'd0);
        send(REQ_INSERT, 10'd0, 8'd0);
        send(REQ_INSERT, 10'd0, 8'd0);
        send(REQ_LOOKUP, 10'd0, 8'd0);
        send(REQ_INSERT, 10'd1023, 8'd255);
        send(REQ_INSERT, 10'd1023, 8'd0);
        send(REQ_INSERT, 10'd1023, 8'd128);
        send(REQ_INSERT, 10'd0, 8'd5);
        send(REQ_LOOKUP, 10'd1023, 8'd128);
        send(REQ_LOOKUP, 10'd1023, 8'd7);
        send(REQ_LOOKUP, 10'd0, 8'd5);
        send(REQ_INSERT, 10'd1022, 8'd1);
        send(REQ_INSERT, 10'd1, 8'd200);
        send(REQ_INSERT, 10'd1, 8'd3);
        send(REQ_LOOKUP, 10'd1, 8'd3);
        send(REQ_LOOKUP, 10'd1, 8'd200);
        send(REQ_LOOKUP, 10'd2, 8'd3);
        send(REQ_INSERT, 10'd2, 8'd255);
        send(REQ_LOOKUP, 10'd1022, 8'd1);
        send(REQ_LOOKUP, 10'd1023, 8'd255);

        base = $urandom;
        for (int n = 0; n < 700; n++) begin
            calm = (n >= 250 && n < 420);
            if (n % 60 == 0) base = $urandom;
            send_random(base);
        end
        calm = 0;

        drain();
        while (sb.used < SLOTS) begin
            send(REQ_INSERT, QF_QUOTIENT_W'($urandom), QF_REMAINDER_W'($urandom));
        end

        for (int n = 0; n < 480; n++) send_random($urandom);
        drain();
        repeat (100) @(posedge i_clk);

        $display("Covered %0d lookups and %0d inserts, %0d found present.",
                 sb.n_lookups, sb.n_inserts, sb.n_hits);
        $display("The filter was filled to all %0d slots; %0d inserts were refused as full.",
                 SLOTS, sb.n_refused);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
